// ===== rtl/bmcd_pkg.sv =====
// Shared constants, codes and types of the binary map corner detector.
// No dependencies; every file but bmcd_ram imports this package.
package bmcd_pkg;

  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_WIDTH  = 4096;
  localparam int WIN_DEPTH  = 2 * MAX_HEIGHT + 3;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int H_W    = $clog2(MAX_HEIGHT) + 1;
  localparam int W_W    = $clog2(MAX_WIDTH) + 1;
  localparam int WA_W   = $clog2(WIN_DEPTH);
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam int H_RESET = 1024;
  localparam int W_RESET = 1024;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic REG_HEIGHT = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] pixel_row;
    logic [COL_W-1:0] pixel_col;
    logic             is_corner;
    logic             last_pixel;
  } out_item_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } pos_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    pos_t             pos;
  } meta_t;

  // window taps by offset from the newest byte
  typedef struct packed {
    logic [PIX_W-1:0] t0;
    logic [PIX_W-1:0] t1;
    logic [PIX_W-1:0] t2;
    logic [PIX_W-1:0] th;
    logic [PIX_W-1:0] th1;
    logic [PIX_W-1:0] th2;
    logic [PIX_W-1:0] t2h;
    logic [PIX_W-1:0] t2h1;
    logic [PIX_W-1:0] t2h2;
  } win_t;

  typedef struct packed {
    meta_t meta;
    win_t  win;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_slot_t;

endpackage

// ===== rtl/bmcd_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module bmcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/bmcd_front.sv =====
// Front end: config registers, input transfer, pending count, scan position,
// window delay line (three bmcd_ram copies) and tap read stage. Uses bmcd_pkg.
module bmcd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bmcd_pkg::in_item_t           in_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bmcd_pkg::CFG_AW-1:0]  paddr,
  input  logic [bmcd_pkg::CFG_DW-1:0]  pwdata,
  output logic [bmcd_pkg::CFG_DW-1:0]  prdata,
  input  logic [bmcd_pkg::Q_AW:0]      q_count,
  output bmcd_pkg::q_slot_t            q_push
);
  import bmcd_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } rc_t;

  logic [H_W-1:0]   h_raw_r, h_eff, h_plus1, pend_r, pend_nxt;
  logic [W_W-1:0]   w_raw_r, w_eff;
  rc_t              out_rc_r, out_rc_nxt;
  logic [WA_W-1:0]  wr_r, wr_nxt;
  logic             accept, is_flush, emit, cfg_wr;
  logic [PIX_W-1:0] push_byte, hist1_r, hist2_r;
  logic             s1_v_r;
  meta_t            meta, s1_meta_r;
  logic [PIX_W-1:0] s1_t0_r, s1_t1_r, s1_t2_r;
  logic [WA_W-1:0]  off_h, off_2h;
  logic [WA_W-1:0]  ra_h, ra_h1, ra_h2, ra_2h, ra_2h1, ra_2h2;
  logic [PIX_W-1:0] rd_h, rd_h1, rd_h2, rd_2h, rd_2h1, rd_2h2;

  function automatic rc_t rc_advance(rc_t cur, logic [H_W-1:0] h, logic [W_W-1:0] w);
    rc_t nxt;
    nxt = cur;
    if (({1'b0, cur.row} + H_W'(1)) >= h) begin
      nxt.row = '0;
      if (({1'b0, cur.col} + W_W'(1)) >= w) begin
        nxt.col = '0;
      end else begin
        nxt.col = cur.col + COL_W'(1);
      end
    end else begin
      nxt.row = cur.row + ROW_W'(1);
    end
    return nxt;
  endfunction

  // circular address of the byte pushed off items before base
  function automatic logic [WA_W-1:0] win_addr(logic [WA_W-1:0] base, logic [WA_W-1:0] off);
    logic [WA_W:0] wrapped;
    wrapped = {1'b0, base} + (WA_W+1)'(WIN_DEPTH) - {1'b0, off};
    return (base >= off) ? (base - off) : wrapped[WA_W-1:0];
  endfunction

  // config port
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_raw_r <= H_W'(H_RESET);
      w_raw_r <= W_W'(W_RESET);
    end else if (cfg_wr) begin
      if (paddr[CFG_AW-1] == REG_HEIGHT) begin
        h_raw_r <= pwdata[H_W-1:0];
      end else begin
        w_raw_r <= pwdata[W_W-1:0];
      end
    end
  end

  assign prdata = (paddr[CFG_AW-1] == REG_WIDTH) ? CFG_DW'(w_raw_r) : CFG_DW'(h_raw_r);

  assign h_eff = (h_raw_r < H_W'(2)) ? H_W'(2) :
                 (h_raw_r > H_W'(MAX_HEIGHT)) ? H_W'(MAX_HEIGHT) : h_raw_r;
  assign w_eff = (w_raw_r < W_W'(2)) ? W_W'(2) :
                 (w_raw_r > W_W'(MAX_WIDTH)) ? W_W'(MAX_WIDTH) : w_raw_r;
  assign h_plus1 = h_eff + H_W'(1);

  // input transfer and classification
  assign in_stall  = (q_count + (Q_AW+1)'(s1_v_r)) >= (Q_AW+1)'(Q_DEPTH);
  assign accept    = in_valid && !in_stall;
  assign is_flush  = (in_data.req_type == REQ_FLUSH);
  assign push_byte = is_flush ? '0 : in_data.pixel_value;

  always_comb begin
    pend_nxt = pend_r;
    emit     = 1'b0;
    if (accept) begin
      if (is_flush) begin
        if (pend_r != '0) begin
          emit     = 1'b1;
          pend_nxt = pend_r - H_W'(1);
        end
      end else if (pend_r < h_plus1) begin
        pend_nxt = pend_r + H_W'(1);
      end else begin
        emit = 1'b1;
      end
    end
  end

  assign out_rc_nxt = emit ? rc_advance(out_rc_r, h_eff, w_eff) : out_rc_r;

  always_comb begin
    meta            = '0;
    meta.row        = out_rc_r.row;
    meta.col        = out_rc_r.col;
    meta.pos.top    = (out_rc_r.row == '0);
    meta.pos.bottom = ({1'b0, out_rc_r.row} == (h_eff - H_W'(1)));
    meta.pos.left   = (out_rc_r.col == '0);
    meta.pos.right  = ({1'b0, out_rc_r.col} == (w_eff - W_W'(1)));
    meta.last       = meta.pos.bottom && meta.pos.right;
  end

  // window delay line
  assign wr_nxt = (wr_r == WA_W'(WIN_DEPTH - 1)) ? '0 : (wr_r + WA_W'(1));
  assign off_h  = WA_W'(h_eff);
  assign off_2h = WA_W'({h_eff, 1'b0});

  assign ra_h   = win_addr(wr_nxt, off_h);
  assign ra_h1  = win_addr(wr_nxt, off_h + WA_W'(1));
  assign ra_h2  = win_addr(wr_nxt, off_h + WA_W'(2));
  assign ra_2h  = win_addr(wr_nxt, off_2h);
  assign ra_2h1 = win_addr(wr_nxt, off_2h + WA_W'(1));
  assign ra_2h2 = win_addr(wr_nxt, off_2h + WA_W'(2));

  bmcd_ram #(.WIDTH(PIX_W), .DEPTH(WIN_DEPTH)) u_ram_a (
    .clk     (clk),
    .we      (accept),
    .waddr   (wr_nxt),
    .wdata   (push_byte),
    .raddr_a (ra_h),
    .raddr_b (ra_h1),
    .rdata_a (rd_h),
    .rdata_b (rd_h1)
  );

  bmcd_ram #(.WIDTH(PIX_W), .DEPTH(WIN_DEPTH)) u_ram_b (
    .clk     (clk),
    .we      (accept),
    .waddr   (wr_nxt),
    .wdata   (push_byte),
    .raddr_a (ra_h2),
    .raddr_b (ra_2h),
    .rdata_a (rd_h2),
    .rdata_b (rd_2h)
  );

  bmcd_ram #(.WIDTH(PIX_W), .DEPTH(WIN_DEPTH)) u_ram_c (
    .clk     (clk),
    .we      (accept),
    .waddr   (wr_nxt),
    .wdata   (push_byte),
    .raddr_a (ra_2h1),
    .raddr_b (ra_2h2),
    .rdata_a (rd_2h1),
    .rdata_b (rd_2h2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      out_rc_r <= '0;
      wr_r     <= '0;
      s1_v_r   <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      out_rc_r <= out_rc_nxt;
      s1_v_r   <= emit;
      if (accept) begin
        wr_r <= wr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist1_r <= push_byte;
      hist2_r <= hist1_r;
    end
    if (emit) begin
      s1_meta_r <= meta;
      s1_t0_r   <= push_byte;
      s1_t1_r   <= hist1_r;
      s1_t2_r   <= hist2_r;
    end
  end

  // RAM read data lands with the read stage
  always_comb begin
    q_push.valid          = s1_v_r;
    q_push.entry.meta     = s1_meta_r;
    q_push.entry.win.t0   = s1_t0_r;
    q_push.entry.win.t1   = s1_t1_r;
    q_push.entry.win.t2   = s1_t2_r;
    q_push.entry.win.th   = rd_h;
    q_push.entry.win.th1  = rd_h1;
    q_push.entry.win.th2  = rd_h2;
    q_push.entry.win.t2h  = rd_2h;
    q_push.entry.win.t2h1 = rd_2h1;
    q_push.entry.win.t2h2 = rd_2h2;
  end

`ifndef SYNTHESIS
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r < WA_W'(WIN_DEPTH))
    else $error("window write pointer out of range");

  a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_flush && (pend_r == '0)) |=> !s1_v_r)
    else $error("flush with nothing pending produced a decision");

  a_fill_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_flush && (pend_r < h_plus1)) |=> !s1_v_r)
    else $error("decision issued while window still filling");
`endif

endmodule

// ===== rtl/bmcd_queue.sv =====
// Four-entry queue of classified decisions between front and back ends.
// Uses bmcd_pkg.
module bmcd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bmcd_pkg::q_slot_t       push,
  input  logic                    pop,
  output bmcd_pkg::q_slot_t       head,
  output logic [bmcd_pkg::Q_AW:0] count
);
  import bmcd_pkg::*;

  q_entry_t          entries_r [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r, rp_r;
  logic [Q_AW:0]     cnt_r;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries_r[wp_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push.valid) begin
        wp_r <= wp_r + Q_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + Q_AW'(1);
      end
      cnt_r <= cnt_r + (Q_AW+1)'(push.valid) - (Q_AW+1)'(pop);
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.entry = entries_r[rp_r];
  assign count      = cnt_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (cnt_r < (Q_AW+1)'(Q_DEPTH)))
    else $error("decision queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("decision queue underflow");
`endif

endmodule

// ===== rtl/bmcd_back.sv =====
// Back end: corner rules on the queued window taps and the output register.
// Uses bmcd_pkg.
module bmcd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bmcd_pkg::q_slot_t   head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bmcd_pkg::out_item_t out_data
);
  import bmcd_pkg::*;

  logic      out_valid_r, load;
  out_item_t out_r, out_nxt;

  function automatic logic corner_of(q_entry_t e);
    logic z_l, z_r, z_u, z_d, z_ul, z_ur, z_dl, z_dr;
    logic res;
    z_l  = (e.win.t2h1 == '0);
    z_r  = (e.win.t1   == '0);
    z_u  = (e.win.th2  == '0);
    z_d  = (e.win.th   == '0);
    z_ul = (e.win.t2h2 == '0);
    z_dl = (e.win.t2h  == '0);
    z_ur = (e.win.t2   == '0);
    z_dr = (e.win.t0   == '0);
    priority if (e.win.th1 != '0) begin
      res = 1'b0;
    end else if ((e.meta.pos.top || e.meta.pos.bottom) &&
                 (e.meta.pos.left || e.meta.pos.right)) begin
      res = 1'b0;
    end else if (e.meta.pos.left) begin
      res = z_r;
    end else if (e.meta.pos.top) begin
      res = z_d;
    end else if (e.meta.pos.right) begin
      res = z_l;
    end else if (e.meta.pos.bottom) begin
      res = z_u;
    end else if (z_l && z_r && ((z_ul && z_ur) || (z_dl && z_dr))) begin
      res = 1'b0;
    end else if (z_u && z_d && ((z_ul && z_dl) || (z_ur && z_dr))) begin
      res = 1'b0;
    end else begin
      res = (e.win.t2h1 != e.win.t1) || (e.win.th2 != e.win.th);
    end
    return res;
  endfunction

  assign load = head.valid && (!out_valid_r || !out_stall);
  assign pop  = load;

  always_comb begin
    out_nxt.pixel_row  = head.entry.meta.row;
    out_nxt.pixel_col  = head.entry.meta.col;
    out_nxt.is_corner  = corner_of(head.entry);
    out_nxt.last_pixel = head.entry.meta.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/binary_map_corner_detector.sv =====
// Top level of the binary map corner detector: front end, decision queue,
// back end. Uses bmcd_pkg, bmcd_front, bmcd_queue, bmcd_back.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+---------------------------------
//   in       | in_valid / in_stall            | in_data  (req_type, pixel_value)
//   out      | out_valid / out_stall          | out_data (row, col, corner, last)
//   config   | psel penable pwrite pready     | paddr, pwdata, prdata
//
// One item per clock while in_stall is low. A decision released by a transfer
// passes the window RAM read stage, the queue and the output register to out_valid.
// Window is three 2051-byte RAM copies (two read ports each), no clearing pass.
// rst_n (sync) clears counters and pointers, image size returns to 1024x1024.
// in_stall rises when the queued decisions plus the RAM read stage fill the four-entry queue;
// out_stall holds the output register.
module binary_map_corner_detector (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bmcd_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bmcd_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bmcd_pkg::CFG_AW-1:0]  paddr,
  input  logic [bmcd_pkg::CFG_DW-1:0]  pwdata,
  output logic [bmcd_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import bmcd_pkg::*;

  q_slot_t       q_push, q_head;
  logic          q_pop;
  logic [Q_AW:0] q_count;

  assign pready = 1'b1;

  bmcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .q_count  (q_count),
    .q_push   (q_push)
  );

  bmcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .count (q_count)
  );

  bmcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for binary_map_corner_detector: column-major pixel
// frames and flush items in, corner decisions out, checked against a predictor.
// Depends on bmcd_pkg and the RTL of the block only.
module tb_top;
  import bmcd_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int TOTAL_ITEMS   = 1850;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  binary_map_corner_detector dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("binary_map_corner_detector test failed");
    $finish;
  end

  // Predictor state
  logic [10:0] cfg_h = 11'(H_RESET);
  logic [12:0] cfg_w = 13'(W_RESET);
  bit [PIX_W-1:0] win_mem [WIN_DEPTH];
  int wr_ptr;
  int in_row, in_col, out_row, out_col;
  int owed_cnt;
  out_item_t decision_q[$];

  in_item_t pixel_q[$];
  int gen_owed;
  int items_sent;
  int mismatches;
  logic in_xfer = 1'b0;

  int burst_left, gap_left;
  int hold_left, mode_left, stall_pct;
  bit long_hold_done;
  bit hold_req;

  function automatic int clamp_height(logic [10:0] v);
    if (v < 2) return 2;
    if (v > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(v);
  endfunction

  function automatic int clamp_width(logic [12:0] v);
    if (v < 2) return 2;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return int'(v);
  endfunction

  // byte pushed k items before the newest one
  function automatic logic [PIX_W-1:0] win_byte(int k);
    return win_mem[(wr_ptr + WIN_DEPTH - (k % WIN_DEPTH)) % WIN_DEPTH];
  endfunction

  task automatic step_pos(inout int row, inout int col, input int h, input int w);
    if (row + 1 >= h) begin
      row = 0;
      col = (col + 1 >= w) ? 0 : col + 1;
    end else begin
      row = row + 1;
    end
  endtask

  function automatic logic corner_at(int h, int w);
    int r, c;
    logic [PIX_W-1:0] l, rt, u, d, ul, ur, dl, dr;
    r = out_row;
    c = out_col;
    if (win_byte(h + 1) != 0) return 1'b0;
    if ((r == 0 || r == h - 1) && (c == 0 || c == w - 1)) return 1'b0;
    if (c == 0) return win_byte(1) == 0;
    if (r == 0) return win_byte(h) == 0;
    if (c == w - 1) return win_byte(2 * h + 1) == 0;
    if (r == h - 1) return win_byte(h + 2) == 0;
    l  = win_byte(2 * h + 1);
    rt = win_byte(1);
    u  = win_byte(h + 2);
    d  = win_byte(h);
    ul = win_byte(2 * h + 2);
    dl = win_byte(2 * h);
    ur = win_byte(2);
    dr = win_byte(0);
    // thick walls
    if (l == 0 && rt == 0 && ((ul == 0 && ur == 0) || (dl == 0 && dr == 0))) return 1'b0;
    if (u == 0 && d == 0 && ((ul == 0 && dl == 0) || (ur == 0 && dr == 0))) return 1'b0;
    return (l != rt || u != d);
  endfunction

  task automatic scan_step(in_item_t it);
    int h, w;
    out_item_t dec;
    h = clamp_height(cfg_h);
    w = clamp_width(cfg_w);
    wr_ptr = (wr_ptr + 1) % WIN_DEPTH;
    if (it.req_type == REQ_FLUSH) begin
      win_mem[wr_ptr] = '0;
      if (owed_cnt == 0) return;
      owed_cnt--;
    end else begin
      win_mem[wr_ptr] = it.pixel_value;
      step_pos(in_row, in_col, h, w);
      if (owed_cnt < h + 1) begin
        owed_cnt++;
        return;
      end
    end
    dec.pixel_row  = ROW_W'(out_row);
    dec.pixel_col  = COL_W'(out_col);
    dec.is_corner  = corner_at(h, w);
    dec.last_pixel = (out_row == h - 1 && out_col == w - 1);
    decision_q = {decision_q, dec};
    step_pos(out_row, out_col, h, w);
  endtask

  // Monitor: checks decisions, feeds accepted items to the predictor.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decision_q.size() == 0) begin
        mismatches++;
        if (mismatches < 50)
          $display("%0t: unexpected decision row %0d col %0d corner %b last %b", $time,
                   out_data.pixel_row, out_data.pixel_col, out_data.is_corner,
                   out_data.last_pixel);
      end else begin
        want = decision_q.pop_front();
        if (out_data.pixel_row !== want.pixel_row || out_data.pixel_col !== want.pixel_col ||
            out_data.is_corner !== want.is_corner ||
            out_data.last_pixel !== want.last_pixel) begin
          mismatches++;
          if (mismatches < 50)
            $display("%0t: expected row %0d col %0d corner %b last %b,", $time,
                     want.pixel_row, want.pixel_col, want.is_corner, want.last_pixel,
                     " got row %0d col %0d corner %b last %b",
                     out_data.pixel_row, out_data.pixel_col, out_data.is_corner,
                     out_data.last_pixel);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) scan_step(in_data);
    in_xfer <= rst_n && in_valid && !in_stall;
  end

  // Driver: bursts with random gaps, payload held while stalled.
  always @(negedge clk) begin : driver
    logic offer;
    in_item_t nxt;
    offer = in_valid;
    nxt = in_data;
    if (rst_n && (!in_valid || in_xfer)) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pixel_q.size() > 0) begin
        nxt = pixel_q.pop_front();
        offer = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          case ($urandom_range(0, 9))
            0: begin
              burst_left = $urandom_range(100, 400);
              gap_left = 0;
            end
            1, 2, 3: begin
              burst_left = 1;
              gap_left = $urandom_range(1, 3);
            end
            default: begin
              burst_left = $urandom_range(1, 16);
              gap_left = $urandom_range(0, 8);
            end
          endcase
        end
      end
    end
    in_valid <= offer;
    in_data <= nxt;
  end

  // Receiver stall pattern, with long holds that back the block up.
  always @(negedge clk) begin : receiver
    logic s;
    if (hold_left > 0) begin
      hold_left--;
      s = 1'b1;
    end else if (!long_hold_done && hold_req) begin
      long_hold_done = 1'b1;
      hold_left = 80;
      s = 1'b1;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      s = ($urandom_range(0, 99) < stall_pct);
      if ($urandom_range(0, 999) == 0) hold_left = $urandom_range(30, 90);
    end
    out_stall <= s;
  end

  task automatic write_reg(logic idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_HEIGHT) cfg_h = val[10:0];
    else cfg_w = val[12:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic push_item(logic kind, logic [PIX_W-1:0] v);
    in_item_t it;
    it.req_type = kind;
    it.pixel_value = v;
    if (kind == REQ_FLUSH) begin
      if (gen_owed > 0) gen_owed--;
    end else if (gen_owed < clamp_height(cfg_h) + 1) begin
      gen_owed++;
    end
    pixel_q = {pixel_q, it};
    items_sent++;
  endtask

  function automatic logic [PIX_W-1:0] rand_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'h00;
      5: return 8'hFF;
      6, 7: return 8'($urandom_range(1, 3));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic load_frames(int n);
    repeat (n * clamp_height(cfg_h) * clamp_width(cfg_w)) push_item(REQ_PIXEL, rand_byte());
  endtask

  task automatic drain();
    while (gen_owed > 0) push_item(REQ_FLUSH, rand_byte());
  endtask

  // Block is idle once every item is taken and every decision is back.
  task automatic wait_idle();
    do @(posedge clk); while (pixel_q.size() != 0 || in_valid || decision_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    gen_owed = owed_cnt;
  endtask

  task automatic random_phase();
    int hv, wv, total, n, left, cap;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        hv = $urandom_range(2, 6);
        wv = $urandom_range(2, 6);
      end
      6, 7: begin
        hv = $urandom_range(0, 16);
        wv = $urandom_range(0, 8);
      end
      default: begin
        hv = $urandom_range(0, 2047);
        wv = $urandom_range(0, 8191);
      end
    endcase
    // every window tap a decision may read has been written since reset
    cap = (items_sent - 3) / 2;
    if (clamp_height(11'(hv)) > cap) hv = cap;
    if ($urandom_range(0, 4) != 0) write_reg(REG_HEIGHT, CFG_DW'(hv));
    if ($urandom_range(0, 4) != 0) write_reg(REG_WIDTH, CFG_DW'(wv));
    total = clamp_height(cfg_h) * clamp_width(cfg_w);
    left = TOTAL_ITEMS - items_sent;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_item(REQ_FLUSH, rand_byte());
    if (total > 300 || 3 * total > left || $urandom_range(0, 3) == 0) begin
      // partial frame with early flushes mixed in
      n = (total < 60) ? total : 60;
      if (n > left) n = left;
      n = $urandom_range(1, n);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) push_item(REQ_FLUSH, rand_byte());
        push_item(REQ_PIXEL, rand_byte());
      end
    end else begin
      load_frames(int'($urandom_range(1, 3)));
    end
    // sometimes leave decisions owed across the next size change
    if ($urandom_range(0, 4) != 0) drain();
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // out-of-range sizes clamp to 2x2; two frames back to back
    write_reg(REG_HEIGHT, CFG_DW'(0));
    write_reg(REG_WIDTH, CFG_DW'(1));
    push_item(REQ_PIXEL, 8'h00);
    push_item(REQ_PIXEL, 8'hFF);
    push_item(REQ_PIXEL, 8'h00);
    push_item(REQ_PIXEL, 8'h00);
    push_item(REQ_PIXEL, 8'h00);
    push_item(REQ_PIXEL, 8'h00);
    push_item(REQ_PIXEL, 8'h01);
    push_item(REQ_PIXEL, 8'h00);
    drain();
    push_item(REQ_FLUSH, 8'hAA);
    wait_idle();

    write_reg(REG_HEIGHT, CFG_DW'(3));
    write_reg(REG_WIDTH, CFG_DW'(3));
    push_item(REQ_PIXEL, 8'h00);
    push_item(REQ_PIXEL, 8'h00);
    push_item(REQ_PIXEL, 8'h00);
    push_item(REQ_PIXEL, 8'h00);
    push_item(REQ_PIXEL, 8'h00);
    push_item(REQ_PIXEL, 8'h05);
    push_item(REQ_PIXEL, 8'h07);
    push_item(REQ_PIXEL, 8'h00);
    push_item(REQ_PIXEL, 8'h00);
    drain();
    wait_idle();

    // long receiver hold while three frames stream in
    write_reg(REG_HEIGHT, CFG_DW'(4));
    write_reg(REG_WIDTH, CFG_DW'(8));
    load_frames(3);
    hold_req = 1'b1;
    drain();
    wait_idle();

    while (items_sent < TOTAL_ITEMS) random_phase();

    drain();
    wait_idle();
    if (mismatches == 0)
      $display("binary_map_corner_detector test passed");
    else
      $display("binary_map_corner_detector test failed");
    $finish;
  end

endmodule

// ===== binary_map_corner_detector.f =====
rtl/bmcd_pkg.sv
rtl/bmcd_ram.sv
rtl/bmcd_front.sv
rtl/bmcd_queue.sv
rtl/bmcd_back.sv
rtl/binary_map_corner_detector.sv
tb/tb_top.sv
